// ===== rtl/mpm_pkg.sv =====
`timescale 1ns / 1ps

package mpm_pkg;

  localparam int DIM_DEF = 4;
  localparam logic [30:0] MOD_RESET = 31'h7FFF_FFFF;
  localparam int RED_STEPS = 62;

  typedef enum logic [1:0] {
    REG_BASE,
    REG_WORK,
    REG_ACC,
    REG_SCR
  } region_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RED,
    ST_LD_WR,
    ST_CP_RD,
    ST_CP_WR,
    ST_INIT,
    ST_CHECK,
    ST_M_RD,
    ST_M_MP,
    ST_M_RED,
    ST_M_ADD,
    ST_EM_RD,
    ST_EM_WR
  } state_t;

endpackage

// ===== rtl/matrix_power_mod.sv =====
`timescale 1ns / 1ps
// Load transfer: the next transfer is taken after the 62-step serial reducer and the write.
// Start transfer: setup copies the base matrix to the work matrix and sets the accumulator to
// the identity, then per exponent bit a check and up to two serially reduced matrix products,
// each followed by a copy, a final check, then output under stalls; one request is in flight.
// Reset is synchronous and active low: modulus returns to 2^31-1 and the base matrix reads
// as all zeros through per-entry valid bits.

module matrix_power_mod
  import mpm_pkg::*;
#(
  parameter int DIM = DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [2:0]  in_row,
  input  logic [2:0]  in_col,
  input  logic [30:0] in_elem_value,
  input  logic [63:0] in_exponent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_row,
  output logic [2:0]  out_col,
  output logic [30:0] out_value,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data
);

  localparam int CELLS = DIM * DIM;
  localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW = IW + 2;
  localparam int DEPTH = 4 * (1 << IW);

  state_t state_r, state_nxt;

  logic [30:0] mod_r;
  logic [30:0] m_eff;
  logic [RW-1:0] r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [61:0] word_r, word_nxt;
  logic [30:0] rem_r, rem_nxt, acc_r, acc_nxt;
  logic [63:0] exp_r, exp_nxt;
  logic mul_sel_r, mul_sel_nxt;
  region_t cp_src_r, cp_src_nxt, cp_dst_r, cp_dst_nxt;
  logic [IW-1:0] ld_idx_r, ld_idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [30:0] out_value_r, out_value_nxt;
  logic out_last_r, out_last_nxt;

  logic [30:0] mem [DEPTH];
  logic [CELLS-1:0] bv_r;
  logic [AW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic [30:0] rd_a_q, rd_b_q, wr_data;
  logic wr_en, rd_bv_q, bv_set;

  logic [IW-1:0] idx_rc, idx_rk, idx_kc;
  logic last_c, last_r, last_k, in_range, in_acc, out_free;
  logic [31:0] red_t, sum_t;
  logic [30:0] red_val, sum_val, one_val;

  assign m_eff = (mod_r == 31'd0) ? 31'd1 : mod_r;
  assign one_val = (m_eff == 31'd1) ? 31'd0 : 31'd1;
  assign idx_rc = IW'(r_r * DIM + c_r);
  assign idx_rk = IW'(r_r * DIM + k_r);
  assign idx_kc = IW'(k_r * DIM + c_r);
  assign last_c = (c_r == RW'(DIM - 1));
  assign last_r = (r_r == RW'(DIM - 1));
  assign last_k = (k_r == RW'(DIM - 1));
  assign in_range = ({1'b0, in_row} < 4'(DIM)) && ({1'b0, in_col} < 4'(DIM));
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign red_t = {rem_r, word_r[61]};
  assign red_val = (red_t >= {1'b0, m_eff}) ? 31'(red_t - {1'b0, m_eff}) : red_t[30:0];
  assign sum_t = {1'b0, acc_r} + {1'b0, rem_r};
  assign sum_val = (sum_t >= {1'b0, m_eff}) ? 31'(sum_t - {1'b0, m_eff}) : sum_t[30:0];

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_row = out_row_r;
  assign out_col = out_col_r;
  assign out_value = out_value_r;
  assign out_last = out_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type) state_nxt = ST_CP_RD;
          else if (in_range) state_nxt = ST_LD_RED;
        end
      end
      ST_LD_RED: if (cnt_r == 6'(RED_STEPS - 1)) state_nxt = ST_LD_WR;
      ST_LD_WR: state_nxt = ST_IDLE;
      ST_CP_RD: state_nxt = ST_CP_WR;
      ST_CP_WR: begin
        if (last_r && last_c) begin
          if (cp_src_r == REG_BASE) state_nxt = ST_INIT;
          else if (!mul_sel_r && (exp_r[63:1] != 63'd0)) state_nxt = ST_M_RD;
          else state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_CP_RD;
        end
      end
      ST_INIT: if (last_r && last_c) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (exp_r == 64'd0) ? ST_EM_RD : ST_M_RD;
      ST_M_RD: state_nxt = ST_M_MP;
      ST_M_MP: state_nxt = ST_M_RED;
      ST_M_RED: if (cnt_r == 6'(RED_STEPS - 1)) state_nxt = ST_M_ADD;
      ST_M_ADD: state_nxt = (last_k && last_r && last_c) ? ST_CP_RD : ST_M_RD;
      ST_EM_RD: state_nxt = ST_EM_WR;
      ST_EM_WR: begin
        if (out_free) state_nxt = (last_r && last_c) ? ST_IDLE : ST_EM_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    r_nxt = r_r;
    c_nxt = c_r;
    k_nxt = k_r;
    cnt_nxt = cnt_r;
    word_nxt = word_r;
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    exp_nxt = exp_r;
    mul_sel_nxt = mul_sel_r;
    cp_src_nxt = cp_src_r;
    cp_dst_nxt = cp_dst_r;
    ld_idx_nxt = ld_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    out_value_nxt = out_value_r;
    out_last_nxt = out_last_r;
    rd_a_addr = {REG_ACC, idx_rc};
    rd_b_addr = {REG_WORK, idx_kc};
    wr_en = 1'b0;
    wr_addr = {REG_SCR, idx_rc};
    wr_data = rem_r;
    bv_set = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type) begin
            exp_nxt = in_exponent;
            cp_src_nxt = REG_BASE;
            cp_dst_nxt = REG_WORK;
            r_nxt = '0;
            c_nxt = '0;
          end else begin
            word_nxt = {31'd0, in_elem_value};
            rem_nxt = '0;
            cnt_nxt = '0;
            ld_idx_nxt = IW'(in_row * DIM + in_col);
          end
        end
      end
      ST_LD_RED, ST_M_RED: begin
        rem_nxt = red_val;
        word_nxt = {word_r[60:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
      end
      ST_LD_WR: begin
        wr_en = 1'b1;
        wr_addr = {REG_BASE, ld_idx_r};
        wr_data = rem_r;
        bv_set = 1'b1;
      end
      ST_CP_RD: rd_a_addr = {cp_src_r, idx_rc};
      ST_CP_WR: begin
        wr_en = 1'b1;
        wr_addr = {cp_dst_r, idx_rc};
        wr_data = (cp_src_r == REG_BASE && !rd_bv_q) ? 31'd0 : rd_a_q;
        c_nxt = last_c ? '0 : c_r + RW'(1);
        if (last_c) r_nxt = last_r ? '0 : r_r + RW'(1);
        if (last_r && last_c && cp_src_r != REG_BASE) begin
          k_nxt = '0;
          acc_nxt = '0;
          if (!mul_sel_r && (exp_r[63:1] != 63'd0)) mul_sel_nxt = 1'b1;
          else exp_nxt = exp_r >> 1;
        end
      end
      ST_INIT: begin
        wr_en = 1'b1;
        wr_addr = {REG_ACC, idx_rc};
        wr_data = (r_r == c_r) ? one_val : 31'd0;
        c_nxt = last_c ? '0 : c_r + RW'(1);
        if (last_c) r_nxt = last_r ? '0 : r_r + RW'(1);
      end
      ST_CHECK: begin
        mul_sel_nxt = !exp_r[0];
        k_nxt = '0;
        acc_nxt = '0;
        r_nxt = '0;
        c_nxt = '0;
      end
      ST_M_RD: begin
        rd_a_addr = {mul_sel_r ? REG_WORK : REG_ACC, idx_rk};
        rd_b_addr = {REG_WORK, idx_kc};
      end
      ST_M_MP: begin
        word_nxt = rd_a_q * rd_b_q;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      ST_M_ADD: begin
        if (last_k) begin
          wr_en = 1'b1;
          wr_addr = {REG_SCR, idx_rc};
          wr_data = sum_val;
          acc_nxt = '0;
          k_nxt = '0;
          c_nxt = last_c ? '0 : c_r + RW'(1);
          if (last_c) r_nxt = last_r ? '0 : r_r + RW'(1);
          cp_src_nxt = REG_SCR;
          cp_dst_nxt = mul_sel_r ? REG_WORK : REG_ACC;
        end else begin
          acc_nxt = sum_val;
          k_nxt = k_r + RW'(1);
        end
      end
      ST_EM_RD, ST_EM_WR: begin
        rd_a_addr = {REG_ACC, idx_rc};
        if (state_r == ST_EM_WR && out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt = 3'(r_r);
          out_col_nxt = 3'(c_r);
          out_value_nxt = rd_a_q;
          out_last_nxt = last_r && last_c;
          c_nxt = last_c ? '0 : c_r + RW'(1);
          if (last_c) r_nxt = last_r ? '0 : r_r + RW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
    rd_bv_q <= bv_r[rd_a_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mod_r <= MOD_RESET;
      bv_r <= '0;
      out_valid_r <= 1'b0;
      r_r <= '0;
      c_r <= '0;
      k_r <= '0;
      cnt_r <= '0;
      exp_r <= '0;
      mul_sel_r <= 1'b0;
      cp_src_r <= REG_BASE;
      cp_dst_r <= REG_WORK;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) mod_r <= cfg_wr_data;
      if (bv_set) bv_r[ld_idx_r] <= 1'b1;
      out_valid_r <= out_valid_nxt;
      r_r <= r_nxt;
      c_r <= c_nxt;
      k_r <= k_nxt;
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
      mul_sel_r <= mul_sel_nxt;
      cp_src_r <= cp_src_nxt;
      cp_dst_r <= cp_dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    ld_idx_r <= ld_idx_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
    out_value_r <= out_value_nxt;
    out_last_r <= out_last_nxt;
  end

  a_rem_residue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_M_ADD) |-> (rem_r < m_eff))
    else $error("reduced term is not a residue");

  a_acc_residue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_M_ADD) |-> (acc_r < m_eff))
    else $error("accumulator is not a residue");

  a_out_residue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r < m_eff))
    else $error("output element is not a residue");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while a request is in progress");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mpm_pkg::*;

  localparam int D = DIM_DEF;
  localparam int CELLS = D * D;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_START = 1'b1;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int SETTLE_CYCLES = 200;

  typedef logic [CELLS-1:0][30:0] mat_t;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [30:0] elem_value;
    logic [63:0] exponent;
  } req_t;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [30:0] value;
    logic        last;
  } elem_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [2:0]  in_row = '0;
  logic [2:0]  in_col = '0;
  logic [30:0] in_elem_value = '0;
  logic [63:0] in_exponent = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_row;
  logic [2:0]  out_col;
  logic [30:0] out_value;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic [30:0] cfg_wr_data = '0;

  req_t  pending_reqs[$];
  elem_t expected_elems[$];
  mat_t  base_copy = '0;
  logic [30:0] cur_modulus = MOD_RESET;
  int snd_idle = 0;
  int rcv_idle = 0;
  bit hold_start = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int errors = 0;
  int cycles = 0;
  int n_loads = 0;
  int n_starts = 0;
  int n_checked = 0;
  req_t drv_req;

  matrix_power_mod #(.DIM(D)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_row(in_row), .in_col(in_col), .in_elem_value(in_elem_value),
    .in_exponent(in_exponent),
    .out_valid(out_valid), .out_stall(out_stall), .out_row(out_row),
    .out_col(out_col), .out_value(out_value), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic mat_t mod_mat_mul(mat_t a, mat_t b, logic [63:0] m);
    mat_t p;
    logic [63:0] s;
    for (int r = 0; r < D; r++) begin
      for (int c = 0; c < D; c++) begin
        s = 0;
        for (int k = 0; k < D; k++) begin
          s = s + 64'(a[r*D+k]) * 64'(b[k*D+c]);
          s = s % m;
        end
        p[r*D+c] = s[30:0];
      end
    end
    return p;
  endfunction

  task automatic predict_power(req_t q);
    logic [63:0] m;
    logic [63:0] e;
    mat_t w;
    mat_t acc;
    elem_t x;
    m = (cur_modulus == 0) ? 64'd1 : 64'(cur_modulus);
    if (q.req_type == REQ_LOAD) begin
      n_loads++;
      if (q.row < D && q.col < D)
        base_copy[q.row*D+q.col] = 31'(64'(q.elem_value) % m);
    end else begin
      n_starts++;
      w = base_copy;
      for (int i = 0; i < CELLS; i++)
        acc[i] = (i / D == i % D) ? 31'(64'd1 % m) : 31'd0;
      e = q.exponent;
      while (e != 0) begin
        if (e[0])
          acc = mod_mat_mul(acc, w, m);
        e = e >> 1;
        w = mod_mat_mul(w, w, m);
      end
      for (int i = 0; i < CELLS; i++) begin
        x.row = 3'(i / D);
        x.col = 3'(i % D);
        x.value = acc[i];
        x.last = (i == CELLS - 1);
        expected_elems.push_back(x);
      end
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        predict_power({in_req_type, in_row, in_col, in_elem_value, in_exponent});
      if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle) begin
        drv_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_req_type <= drv_req.req_type;
        in_row <= drv_req.row;
        in_col <= drv_req.col;
        in_elem_value <= drv_req.elem_value;
        in_exponent <= drv_req.exponent;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_start && !hold_done && out_valid) begin
      hold_done <= 1'b1;
      hold_left <= 2000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    elem_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_elems.size() == 0) begin
        report("unexpected transfer, value", 64'(out_value), 0);
      end else begin
        want = expected_elems.pop_front();
        n_checked++;
        if (out_row != want.row) report("row", 64'(out_row), 64'(want.row));
        if (out_col != want.col) report("col", 64'(out_col), 64'(want.col));
        if (out_value != want.value) report("value", 64'(out_value), 64'(want.value));
        if (out_last != want.last) report("last", 64'(out_last), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding.", expected_elems.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic req_t load_req(int r, int c, logic [30:0] v);
    req_t q;
    q = '0;
    q.req_type = REQ_LOAD;
    q.row = 3'(r);
    q.col = 3'(c);
    q.elem_value = v;
    return q;
  endfunction

  function automatic req_t start_req(logic [63:0] e);
    req_t q;
    q = '0;
    q.req_type = REQ_START;
    q.exponent = e;
    q.row = 3'($urandom_range(7));
    q.col = 3'($urandom_range(7));
    q.elem_value = 31'($urandom);
    return q;
  endfunction

  function automatic req_t random_req();
    int bits;
    logic [63:0] e;
    if ($urandom_range(99) < 75) begin
      if ($urandom_range(9) == 0)
        return load_req($urandom_range(7), $urandom_range(7), 31'($urandom));
      return load_req($urandom_range(D - 1), $urandom_range(D - 1),
                      ($urandom_range(9) == 0) ? 31'h7FFF_FFFF : 31'($urandom));
    end
    bits = ($urandom_range(9) == 0) ? $urandom_range(8) : $urandom_range(3);
    e = {$urandom, $urandom};
    e = (bits == 0) ? 64'd0 : (e & ((64'd1 << bits) - 1));
    return start_req(e);
  endfunction

  task automatic settle();
    while (pending_reqs.size() > 0 || in_valid || expected_elems.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(logic [30:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_modulus = v;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      pending_reqs.push_back(random_req());
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle = 15;
    rcv_idle = 50;
    pending_reqs.push_back(start_req(64'd0));
    pending_reqs.push_back(start_req(64'd1));
    pending_reqs.push_back(load_req(0, 0, 31'h7FFF_FFFF));
    pending_reqs.push_back(load_req(D - 1, D - 1, 31'h7FFF_FFFE));
    pending_reqs.push_back(load_req(0, D - 1, 31'd3));
    pending_reqs.push_back(load_req(D - 1, 0, 31'd0));
    pending_reqs.push_back(load_req(7, 0, 31'd5));
    pending_reqs.push_back(load_req(0, 7, 31'd5));
    pending_reqs.push_back(load_req(D, D, 31'd9));
    pending_reqs.push_back(load_req(1, 2, 31'h5555_5555));
    pending_reqs.push_back(load_req(2, 1, 31'h2AAA_AAAA));
    pending_reqs.push_back(start_req(64'd1));
    pending_reqs.push_back(start_req(64'd2));
    pending_reqs.push_back(start_req(64'd5));
    settle();

    write_modulus(31'd1);
    pending_reqs.push_back(start_req(64'd3));
    pending_reqs.push_back(load_req(1, 1, 31'd7));
    pending_reqs.push_back(start_req(64'd0));
    settle();

    write_modulus(31'd0);
    pending_reqs.push_back(start_req(64'd0));
    pending_reqs.push_back(start_req(64'd2));
    settle();

    write_modulus(31'd7);
    pending_reqs.push_back(start_req(64'd0));
    pending_reqs.push_back(start_req(64'd6));
    random_phase(20);

    snd_idle = 50;
    rcv_idle = 15;
    write_modulus(31'h7FFF_FFFF);
    pending_reqs.push_back(start_req(64'hFFFF_FFFF_FFFF_FFFF));
    random_phase(25);

    write_modulus(31'($urandom_range(2, 1000)));
    random_phase(20);

    snd_idle = 0;
    rcv_idle = 0;
    write_modulus(31'($urandom) | 31'h4000_0000);
    hold_start = 1;
    pending_reqs.push_back(start_req(64'd3));
    for (int i = 0; i < 8; i++)
      pending_reqs.push_back(load_req($urandom_range(D - 1), $urandom_range(D - 1),
                                      31'($urandom)));
    pending_reqs.push_back(start_req(64'd2));
    random_phase(25);

    $display("Covered %0d loads and %0d exponentiations, %0d result elements checked,",
             n_loads, n_starts, n_checked);
    $display("across moduli from zero to 2^31-1 and exponents from zero to all ones.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mpm_pkg.sv
rtl/matrix_power_mod.sv
verif/tb_top.sv
